[src/hrsc_pkg.sv]
// ----------------------------------------------------------------------------
// hrsc_pkg: shared types and constants for the ramped h-bridge speed control
// Direction codes, configuration register indexes, reset values and the
// reciprocal used to divide the pwm product by one hundred.
// ----------------------------------------------------------------------------
package hrsc_pkg;

	// bridge direction codes
	typedef enum logic [1:0] {
		DIR_STOP = 2'd0,
		DIR_FWD  = 2'd1,
		DIR_REV  = 2'd2
	} dir_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_RAMP_STEP      = 2'd0,
		CFG_RAMP_INTERVAL  = 2'd1,
		CFG_REVERSAL_DELAY = 2'd2,
		CFG_PWM_TOP        = 2'd3
	} cfg_index_t;

	localparam int CfgIndexWidth = 2;
	localparam int CfgDataWidth  = 16;

	// register reset values, also used when zero is written, except for the pwm top
	localparam logic [6:0]  RampStepDefault      = 7'd5;
	localparam logic [15:0] RampIntervalDefault  = 16'd20;
	localparam logic [15:0] ReversalDelayDefault = 16'd100;
	localparam logic [15:0] PwmTopDefault        = 16'd999;

	// speed limits in percent
	localparam logic signed [7:0] SpeedMax = 8'sd100;
	localparam logic signed [7:0] SpeedMin = -8'sd100;

	// floor(x / 100) = (x * DivRecip) >> DivShift, exact for x below 2**23
	localparam int          ProdWidth = 24;
	localparam int          DivShift  = 30;
	localparam logic [23:0] DivRecip  = 24'd10737419;

endpackage

[src/hrsc_if.sv]
// ----------------------------------------------------------------------------
// hrsc_if: handshake channels of the ramped h-bridge speed control
// One interface for the tick input and one for the drive result.
// ----------------------------------------------------------------------------
interface hrsc_tick_if;
	logic              valid;
	logic              ready;
	logic [31:0]       time_now;
	logic signed [7:0] speed_request;

	modport source (output valid, output time_now, output speed_request, input ready);
	modport sink   (input valid, input time_now, input speed_request, output ready);
endinterface

interface hrsc_result_if;
	logic              valid;
	logic              ready;
	logic              drive_a;
	logic              drive_b;
	logic [15:0]       compare_value;
	logic [6:0]        duty_now;
	logic signed [7:0] signed_speed;
	logic [1:0]        direction_state;
	logic              reversal_pending;

	modport source (output valid, output drive_a, output drive_b, output compare_value,
		output duty_now, output signed_speed, output direction_state,
		output reversal_pending, input ready);
	modport sink   (input valid, input drive_a, input drive_b, input compare_value,
		input duty_now, input signed_speed, input direction_state,
		input reversal_pending, output ready);
endinterface

[src/hbridge_ramped_speed_control_core.sv]
// ----------------------------------------------------------------------------
// hbridge_ramped_speed_control_core: soft-start h-bridge speed control
// Ramps the applied duty toward the requested speed, holds the bridge in stop
// for a dead time on reversal, and produces drive bits and a pwm compare value.
// ----------------------------------------------------------------------------
//
//   channel   dir   handshake      word
//   tick      in    valid/ready    time_now, speed_request
//   result    out   valid/ready    drive_a, drive_b, compare_value, duty_now,
//                                  signed_speed, direction_state, reversal_pending
//   cfg       in    cfg_wr_en      cfg_index, cfg_wdata
//
// one word per cycle sustained while result is ready; each tick passes through the stages below
// stages: input register, state update, pwm product, divide by 100 and cap
// the state registers update once per tick as it leaves the input register
// each stage holds while the one after it is full and stalled; bubbles close up
// reset clears all control state and loads the configuration defaults
//
module hbridge_ramped_speed_control_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [hrsc_pkg::CfgIndexWidth-1:0] cfg_index,
	input  logic [hrsc_pkg::CfgDataWidth-1:0]  cfg_wdata,
	hrsc_tick_if.sink                          tick,
	hrsc_result_if.source                      result
);

	// configuration registers
	logic [6:0]  ramp_step_q;
	logic [15:0] ramp_interval_q;
	logic [15:0] reversal_delay_q;
	logic [15:0] pwm_top_q;

	// controller state
	logic [6:0]     duty_q;
	hrsc_pkg::dir_t pres_q;
	hrsc_pkg::dir_t pend_q;
	logic [31:0]    deadline_q;
	logic [31:0]    last_ramp_q;

	// pipeline
	logic              v_s1, v_s2, v_s3, v_s4;
	logic              adv_s1, adv_s2, adv_s3, adv_s4;
	logic [31:0]       time_s1;
	logic signed [7:0] req_s1;
	logic [6:0]        duty_s2, duty_s3;
	hrsc_pkg::dir_t    dir_s2, dir_s3;
	logic              pend_s2, pend_s3;
	logic [hrsc_pkg::ProdWidth-1:0] prod_s3;

	// next-state logic
	logic signed [7:0] req_clamp;
	hrsc_pkg::dir_t    req_dir;
	logic [6:0]        req_mag;
	logic [6:0]        target;
	logic [7:0]        duty_sum;
	logic [31:0]       dl_diff;
	logic [31:0]       ramp_diff;
	logic              ramp_due;
	logic              hold;
	logic [6:0]        duty_n;
	hrsc_pkg::dir_t    pres_n;
	hrsc_pkg::dir_t    pend_n;
	logic [31:0]       deadline_n;
	logic [31:0]       last_ramp_n;

	// divide stage
	logic [16:0]       top_plus1;
	logic [2*hrsc_pkg::ProdWidth-1:0] recip_prod;
	logic [16:0]       quot;
	logic [15:0]       cmp_c;

	// stall control, each stage moves when the next one can take its word
	assign adv_s4     = !v_s4 || result.ready;
	assign adv_s3     = !v_s3 || adv_s4;
	assign adv_s2     = !v_s2 || adv_s3;
	assign adv_s1     = !v_s1 || adv_s2;
	assign tick.ready = adv_s1;

	// configuration writes, zero falls back to the default except for the pwm top
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramp_step_q      <= hrsc_pkg::RampStepDefault;
			ramp_interval_q  <= hrsc_pkg::RampIntervalDefault;
			reversal_delay_q <= hrsc_pkg::ReversalDelayDefault;
			pwm_top_q        <= hrsc_pkg::PwmTopDefault;
		end else if (cfg_wr_en) begin
			unique case (hrsc_pkg::cfg_index_t'(cfg_index))
				hrsc_pkg::CFG_RAMP_STEP: begin
					ramp_step_q <= (cfg_wdata[6:0] == 7'd0) ?
						hrsc_pkg::RampStepDefault : cfg_wdata[6:0];
				end
				hrsc_pkg::CFG_RAMP_INTERVAL: begin
					ramp_interval_q <= (cfg_wdata == 16'd0) ?
						hrsc_pkg::RampIntervalDefault : cfg_wdata;
				end
				hrsc_pkg::CFG_REVERSAL_DELAY: begin
					reversal_delay_q <= (cfg_wdata == 16'd0) ?
						hrsc_pkg::ReversalDelayDefault : cfg_wdata;
				end
				hrsc_pkg::CFG_PWM_TOP: begin
					pwm_top_q <= cfg_wdata;
				end
				default: begin
				end
			endcase
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= tick.valid;
			if (adv_s2) v_s2 <= v_s1;
			if (adv_s3) v_s3 <= v_s2;
			if (adv_s4) v_s4 <= v_s3;
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (adv_s1 && tick.valid) begin
			time_s1 <= tick.time_now;
			req_s1  <= tick.speed_request;
		end
	end

	// wrap-safe time differences
	assign dl_diff   = time_s1 - deadline_q;
	assign ramp_diff = time_s1 - last_ramp_q;
	assign ramp_due  = ramp_diff >= {16'd0, ramp_interval_q};

	// request decode, dead time, reversal and ramp
	always_comb begin
		req_clamp   = req_s1;
		req_dir     = hrsc_pkg::DIR_STOP;
		req_mag     = 7'd0;
		target      = 7'd0;
		duty_sum    = 8'd0;
		hold        = 1'b0;
		duty_n      = duty_q;
		pres_n      = pres_q;
		pend_n      = pend_q;
		deadline_n  = deadline_q;
		last_ramp_n = last_ramp_q;

		// clamp to plus or minus 100 and split into direction and magnitude
		priority if (req_s1 > hrsc_pkg::SpeedMax) begin
			req_clamp = hrsc_pkg::SpeedMax;
		end else if (req_s1 < hrsc_pkg::SpeedMin) begin
			req_clamp = hrsc_pkg::SpeedMin;
		end else begin
			req_clamp = req_s1;
		end
		priority if (req_clamp > 8'sd0) begin
			req_dir = hrsc_pkg::DIR_FWD;
			req_mag = req_clamp[6:0];
		end else if (req_clamp < 8'sd0) begin
			req_dir = hrsc_pkg::DIR_REV;
			req_mag = 7'(8'd0 - req_clamp);
		end else begin
			req_dir = hrsc_pkg::DIR_STOP;
			req_mag = 7'd0;
		end

		// dead time: hold everything until the deadline is reached
		if (pend_q != hrsc_pkg::DIR_STOP) begin
			if (!dl_diff[31]) begin
				pres_n = pend_q;
				pend_n = hrsc_pkg::DIR_STOP;
			end else begin
				hold = 1'b1;
			end
		end

		if (!hold) begin
			priority if (req_dir != hrsc_pkg::DIR_STOP && pres_n != hrsc_pkg::DIR_STOP &&
				req_dir != pres_n) begin
				// reversal request: cut duty, stop, start the dead time
				duty_n     = 7'd0;
				pres_n     = hrsc_pkg::DIR_STOP;
				pend_n     = req_dir;
				deadline_n = time_s1 + {16'd0, reversal_delay_q};
			end else begin
				if (pres_n == hrsc_pkg::DIR_STOP && req_dir != hrsc_pkg::DIR_STOP) begin
					pres_n = req_dir;
				end
				target = (req_dir == pres_n) ? req_mag : 7'd0;

				// one ramp step per interval, bounded by the target
				if (ramp_due) begin
					last_ramp_n = time_s1;
					duty_sum    = {1'b0, duty_q} + {1'b0, ramp_step_q};
					priority if (duty_q < target) begin
						duty_n = (duty_sum > {1'b0, target}) ? target : duty_sum[6:0];
					end else if (duty_q > target) begin
						duty_n = (duty_q > ramp_step_q) ? (duty_q - ramp_step_q) : 7'd0;
						if (duty_n < target) begin
							duty_n = target;
						end
					end else begin
						duty_n = duty_q;
					end
				end

				// coasted to zero with no request: back to stop
				if (duty_n == 7'd0 && req_dir == hrsc_pkg::DIR_STOP &&
					pres_n != hrsc_pkg::DIR_STOP) begin
					pres_n = hrsc_pkg::DIR_STOP;
				end
			end
		end
	end

	// controller state, updated as a word leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_q      <= 7'd0;
			pres_q      <= hrsc_pkg::DIR_STOP;
			pend_q      <= hrsc_pkg::DIR_STOP;
			deadline_q  <= 32'd0;
			last_ramp_q <= 32'd0;
		end else if (v_s1 && adv_s2) begin
			duty_q      <= duty_n;
			pres_q      <= pres_n;
			pend_q      <= pend_n;
			deadline_q  <= deadline_n;
			last_ramp_q <= last_ramp_n;
		end
	end

	// snapshot of the updated state
	always_ff @(posedge clk) begin
		if (v_s1 && adv_s2) begin
			duty_s2 <= duty_n;
			dir_s2  <= pres_n;
			pend_s2 <= (pend_n != hrsc_pkg::DIR_STOP);
		end
	end

	// pwm product (top + 1) * duty
	assign top_plus1 = {1'b0, pwm_top_q} + 17'd1;

	always_ff @(posedge clk) begin
		if (v_s2 && adv_s3) begin
			prod_s3 <= hrsc_pkg::ProdWidth'(top_plus1) * hrsc_pkg::ProdWidth'(duty_s2);
			duty_s3 <= duty_s2;
			dir_s3  <= dir_s2;
			pend_s3 <= pend_s2;
		end
	end

	// divide by 100 through the reciprocal, then cap at top
	assign recip_prod = prod_s3 * hrsc_pkg::DivRecip;
	assign quot       = recip_prod[hrsc_pkg::DivShift +: 17];
	assign cmp_c      = (quot > {1'b0, pwm_top_q}) ? pwm_top_q : quot[15:0];

	// result register
	always_ff @(posedge clk) begin
		if (v_s3 && adv_s4) begin
			result.drive_a          <= (dir_s3 == hrsc_pkg::DIR_FWD);
			result.drive_b          <= (dir_s3 == hrsc_pkg::DIR_REV);
			result.compare_value    <= cmp_c;
			result.duty_now         <= duty_s3;
			result.direction_state  <= dir_s3;
			result.reversal_pending <= pend_s3;
			unique case (dir_s3)
				hrsc_pkg::DIR_FWD: result.signed_speed <= {1'b0, duty_s3};
				hrsc_pkg::DIR_REV: result.signed_speed <= 8'(8'd0 - {1'b0, duty_s3});
				default:           result.signed_speed <= 8'sd0;
			endcase
		end
	end

	assign result.valid = v_s4;

endmodule
